// ===== src/mbrtu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrtu_pkg
// Shared codes, controller/datapath command and status types, and the
// byte-wise CRC-16 step used by the Modbus RTU master.
// ----------------------------------------------------------------------------
package mbrtu_pkg;

  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_BYTE  = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  localparam logic KIND_TX   = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CRC     = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;
  localparam logic [1:0] ST_ECHO    = 2'd3;

  localparam logic [7:0] FC_READ_HOLDING = 8'd3;
  localparam logic [7:0] FC_READ_INPUT   = 8'd4;

  localparam logic [2:0] DT_UINT16 = 3'd1;
  localparam logic [2:0] DT_UINT32 = 3'd2;
  localparam logic [2:0] DT_INT32  = 3'd4;
  localparam logic [2:0] DT_INT16  = 3'd5;

  localparam logic [2:0] ORD_ABCD = 3'd1;
  localparam logic [2:0] ORD_CDAB = 3'd2;
  localparam logic [2:0] ORD_BADC = 3'd3;
  localparam logic [2:0] ORD_DCBA = 3'd4;

  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  localparam int FRAME_LEN = 8;
  localparam int RESP_LEN  = 9;

  localparam logic [3:0] LEN_SHORT = 4'd7;
  localparam logic [3:0] LEN_ECHO  = 4'd8;
  localparam logic [3:0] LEN_LONG  = 4'd9;

  typedef struct packed {
    logic       load;
    logic       tx_step;
    logic [2:0] tx_idx;
    logic       rx_take;
    logic       tick_take;
  } dp_cmd_t;

  typedef struct packed {
    logic rx_last;
    logic timeout_hit;
  } dp_sts_t;

  function automatic logic [15:0] crc_byte(logic [15:0] crc_in, logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic is_short(logic [2:0] t);
    return (t == DT_UINT16) || (t == DT_INT16);
  endfunction

endpackage

// ===== src/modbus_rtu_master_transaction.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_rtu_master_transaction
// Modbus RTU master handling one transaction at a time: sends the 8-byte
// request with CRC-16, collects and checks the response, reports completion.
//
//   channel   handshake          word
//   -------   ----------------   ---------------------------------------------
//   in_       start / busy       func, station, opcode, reg_address,
//                                write_word, dtype, byte_order, rx_byte
//   out_      out_valid strobe   kind, tx_byte, last_of_run, status, value
//   cfg_      cfg_we             cfg_wdata -> timeout_ticks
//
// A start word holds busy high while the request goes out, one byte per
// cycle through the shared byte-wise CRC unit; each byte reaches the out_
// port through the result register after the controller steps it.
// Received-byte and tick words are taken every cycle in S_WAIT; a completion
// appears in the next cycle. Reset is synchronous and needs no clearing pass.
// Results are single-cycle strobes; the receiver cannot stall them.
// ----------------------------------------------------------------------------
module modbus_rtu_master_transaction (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_station,
  input  logic [7:0]  in_opcode,
  input  logic [15:0] in_reg_address,
  input  logic [15:0] in_write_word,
  input  logic [2:0]  in_dtype,
  input  logic [2:0]  in_byte_order,
  input  logic [7:0]  in_rx_byte,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output logic        out_valid,
  output logic        out_kind,
  output logic [7:0]  out_tx_byte,
  output logic        out_last_of_run,
  output logic [1:0]  out_status,
  output logic [31:0] out_value
);
  import mbrtu_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  mbrtu_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .func  (in_func),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  mbrtu_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .station         (in_station),
    .opcode          (in_opcode),
    .reg_address     (in_reg_address),
    .write_word      (in_write_word),
    .dtype           (in_dtype),
    .byte_order      (in_byte_order),
    .rx_byte         (in_rx_byte),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_tx_byte     (out_tx_byte),
    .out_last_of_run (out_last_of_run),
    .out_status      (out_status),
    .out_value       (out_value)
  );

endmodule

// ===== src/mbrtu_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrtu_ctrl
// Transaction controller: accepts words, steps the request transmit
// sequence and tracks whether a response is awaited.
// ----------------------------------------------------------------------------
module mbrtu_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [1:0]          func,
  output logic                busy,
  output mbrtu_pkg::dp_cmd_t  cmd,
  input  mbrtu_pkg::dp_sts_t  sts
);
  import mbrtu_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TX   = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  localparam logic [2:0] TX_LAST = 3'(FRAME_LEN - 1);

  logic [1:0] state_r, state_nxt;
  logic [2:0] tx_cnt_r, tx_cnt_nxt;
  logic       accept;
  logic       finish;

  assign busy   = (state_r == S_TX);
  assign accept = start & ~busy;

  always_comb begin
    cmd.load      = accept && (func == FUNC_START);
    cmd.tx_step   = (state_r == S_TX);
    cmd.tx_idx    = tx_cnt_r;
    cmd.rx_take   = accept && (state_r == S_WAIT) && (func == FUNC_BYTE);
    cmd.tick_take = accept && (state_r == S_WAIT) && (func == FUNC_TICK);
  end

  assign finish = (cmd.rx_take && sts.rx_last) || (cmd.tick_take && sts.timeout_hit);

  always_comb begin
    state_nxt  = state_r;
    tx_cnt_nxt = tx_cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.load) begin
          state_nxt  = S_TX;
          tx_cnt_nxt = '0;
        end
      end
      S_TX: begin
        tx_cnt_nxt = tx_cnt_r + 3'd1;
        if (tx_cnt_r == TX_LAST) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (cmd.load) begin
          state_nxt  = S_TX;
          tx_cnt_nxt = '0;
        end else if (finish) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      tx_cnt_r <= '0;
    end else begin
      state_r  <= state_nxt;
      tx_cnt_r <= tx_cnt_nxt;
    end
  end

endmodule

// ===== src/mbrtu_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrtu_dp
// Datapath: request frame, shared CRC-16 byte unit, response capture,
// timeout counter, value assembly and registered result port.
// ----------------------------------------------------------------------------
module mbrtu_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  mbrtu_pkg::dp_cmd_t  cmd,
  output mbrtu_pkg::dp_sts_t  sts,
  input  logic [7:0]          station,
  input  logic [7:0]          opcode,
  input  logic [15:0]         reg_address,
  input  logic [15:0]         write_word,
  input  logic [2:0]          dtype,
  input  logic [2:0]          byte_order,
  input  logic [7:0]          rx_byte,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata,
  output logic                out_valid,
  output logic                out_kind,
  output logic [7:0]          out_tx_byte,
  output logic                out_last_of_run,
  output logic [1:0]          out_status,
  output logic [31:0]         out_value
);
  import mbrtu_pkg::*;

  localparam logic [2:0] IDX_CRC_LO = 3'(FRAME_LEN - 2);
  localparam logic [2:0] IDX_CRC_HI = 3'(FRAME_LEN - 1);
  localparam logic [3:0] RESP_MAX   = 4'(RESP_LEN);

  logic [7:0]  frame_r [0:FRAME_LEN-1];
  logic [7:0]  resp_r  [0:RESP_LEN-1];
  logic [15:0] crc_r;
  logic [15:0] elapsed_r;
  logic [15:0] timeout_r;
  logic [3:0]  rx_cnt_r;
  logic        pend_read_r;
  logic [2:0]  pend_type_r;
  logic [2:0]  pend_order_r;

  logic        out_valid_r;
  logic        out_kind_r;
  logic [7:0]  out_tx_byte_r;
  logic        out_last_r;
  logic [1:0]  out_status_r;
  logic [31:0] out_value_r;

  logic        req_read;
  logic [15:0] req_word;
  logic [7:0]  tx_byte_sel;
  logic [7:0]  crc_in_byte;
  logic [15:0] crc_upd;
  logic [3:0]  exp_len;
  logic [3:0]  rx_cnt_inc;
  logic [7:0]  crc_lo_rx;
  logic        crc_ok;
  logic        echo_ok;
  logic [31:0] asm_value;
  logic [1:0]  rx_status;
  logic [31:0] rx_value;
  logic        done_evt;

  function automatic logic [31:0] assemble(logic [2:0] t, logic [2:0] o, logic [7:0] a,
                                           logic [7:0] b, logic [7:0] c, logic [7:0] d);
    logic [31:0] w;
    w = '0;
    if (is_short(t)) begin
      priority if (o == ORD_ABCD) begin
        w = {16'h0000, a, b};
      end else if (o == ORD_DCBA) begin
        w = {16'h0000, b, a};
      end else begin
        w = '0;
      end
      if (t == DT_INT16 && w[15]) begin
        w[31:16] = 16'hFFFF;
      end
    end else if (t >= DT_UINT32 && t <= DT_INT32) begin
      priority if (o == ORD_ABCD) begin
        w = {a, b, c, d};
      end else if (o == ORD_CDAB) begin
        w = {c, d, a, b};
      end else if (o == ORD_BADC) begin
        w = {b, a, d, c};
      end else if (o == ORD_DCBA) begin
        w = {d, c, b, a};
      end else begin
        w = '0;
      end
    end
    return w;
  endfunction

  assign req_read = (opcode == FC_READ_HOLDING) || (opcode == FC_READ_INPUT);
  assign req_word = req_read ? (is_short(dtype) ? 16'd1 : 16'd2) : write_word;

  always_comb begin
    priority if (cmd.tx_idx == IDX_CRC_LO) begin
      tx_byte_sel = crc_r[7:0];
    end else if (cmd.tx_idx == IDX_CRC_HI) begin
      tx_byte_sel = crc_r[15:8];
    end else begin
      tx_byte_sel = frame_r[cmd.tx_idx];
    end
  end

  // one crc unit shared by transmit and receive
  assign crc_in_byte = cmd.tx_step ? tx_byte_sel : rx_byte;
  assign crc_upd     = crc_byte(crc_r, crc_in_byte);

  assign exp_len    = pend_read_r ? (is_short(pend_type_r) ? LEN_SHORT : LEN_LONG) : LEN_ECHO;
  assign rx_cnt_inc = rx_cnt_r + 4'd1;

  always_comb begin
    priority if (exp_len == LEN_SHORT) begin
      crc_lo_rx = resp_r[5];
    end else if (exp_len == LEN_ECHO) begin
      crc_lo_rx = resp_r[6];
    end else begin
      crc_lo_rx = resp_r[7];
    end
  end

  assign crc_ok = (crc_lo_rx == crc_r[7:0]) && (rx_byte == crc_r[15:8]);

  always_comb begin
    echo_ok = (rx_byte == frame_r[FRAME_LEN-1]);
    for (int i = 0; i < FRAME_LEN - 1; i++) begin
      echo_ok = echo_ok && (resp_r[i] == frame_r[i]);
    end
  end

  assign asm_value = assemble(pend_type_r, pend_order_r, resp_r[3], resp_r[4],
                              resp_r[5], resp_r[6]);

  always_comb begin
    rx_status = ST_OK;
    rx_value  = '0;
    priority if (!crc_ok) begin
      rx_status = ST_CRC;
    end else if (pend_read_r) begin
      rx_value = asm_value;
    end else if (!echo_ok) begin
      rx_status = ST_ECHO;
    end else begin
      rx_status = ST_OK;
    end
  end

  assign sts.rx_last     = (rx_cnt_inc == exp_len);
  assign sts.timeout_hit = (elapsed_r >= timeout_r);

  assign done_evt = (cmd.rx_take && sts.rx_last) || (cmd.tick_take && sts.timeout_hit);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r    <= TIMEOUT_RESET;
      crc_r        <= CRC_INIT;
      elapsed_r    <= '0;
      rx_cnt_r     <= '0;
      pend_read_r  <= 1'b0;
      pend_type_r  <= '0;
      pend_order_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        timeout_r <= cfg_wdata;
      end
      if (cmd.load) begin
        crc_r        <= CRC_INIT;
        elapsed_r    <= '0;
        rx_cnt_r     <= '0;
        pend_read_r  <= req_read;
        pend_type_r  <= dtype;
        pend_order_r <= byte_order;
      end else if (cmd.tx_step) begin
        if (cmd.tx_idx < IDX_CRC_LO) begin
          crc_r <= crc_upd;
        end else if (cmd.tx_idx == IDX_CRC_HI) begin
          crc_r <= CRC_INIT;
        end
      end else if (cmd.rx_take) begin
        if ((5'(rx_cnt_r) + 5'd2) < 5'(exp_len)) begin
          crc_r <= crc_upd;
        end
        rx_cnt_r <= rx_cnt_inc;
      end else if (cmd.tick_take && !sts.timeout_hit) begin
        elapsed_r <= elapsed_r + 16'd1;
      end
      out_valid_r <= cmd.tx_step || done_evt;
    end
  end

  // frame, response and result words
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      frame_r[0] <= station;
      frame_r[1] <= opcode;
      frame_r[2] <= reg_address[15:8];
      frame_r[3] <= reg_address[7:0];
      frame_r[4] <= req_word[15:8];
      frame_r[5] <= req_word[7:0];
    end else if (cmd.tx_step && cmd.tx_idx == IDX_CRC_LO) begin
      frame_r[FRAME_LEN-2] <= crc_r[7:0];
      frame_r[FRAME_LEN-1] <= crc_r[15:8];
    end
    if (cmd.rx_take && rx_cnt_r < RESP_MAX) begin
      resp_r[rx_cnt_r] <= rx_byte;
    end
    if (cmd.tx_step) begin
      out_kind_r    <= KIND_TX;
      out_tx_byte_r <= tx_byte_sel;
      out_last_r    <= (cmd.tx_idx == IDX_CRC_HI);
      out_status_r  <= ST_OK;
      out_value_r   <= '0;
    end else begin
      out_kind_r    <= KIND_DONE;
      out_tx_byte_r <= '0;
      out_last_r    <= 1'b0;
      out_status_r  <= cmd.rx_take ? rx_status : ST_TIMEOUT;
      out_value_r   <= cmd.rx_take ? rx_value : 32'h0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_tx_byte     = out_tx_byte_r;
  assign out_last_of_run = out_last_r;
  assign out_status      = out_status_r;
  assign out_value       = out_value_r;

endmodule
